// File: rtl/core/hsc_pkg.sv
`default_nettype none
package hsc_pkg;

	localparam int unsigned DivBits = 32;

	localparam logic [2:0] RegTempCoeffs  = 3'd0;
	localparam logic [2:0] RegPressCoeffA = 3'd1;
	localparam logic [2:0] RegPressCoeffB = 3'd2;
	localparam logic [2:0] RegPressCoeff9 = 3'd3;
	localparam logic [2:0] RegHumCoeffs   = 3'd4;

	localparam logic signed [31:0] TempMin     = -32'sd4000;
	localparam logic signed [31:0] TempMax     = 32'sd8500;
	localparam logic [31:0]        PressMin    = 32'd30000;
	localparam logic [31:0]        PressMax    = 32'd110000;
	localparam logic signed [31:0] HumLimit    = 32'sd419430400;
	localparam logic [16:0]        HumMax      = 17'd102400;
	localparam logic [31:0]        PressOffset = 32'd1048576;
	localparam logic [31:0]        PressScale  = 32'd3125;
	localparam logic signed [31:0] FinePress   = 32'sd64000;
	localparam logic signed [31:0] FineHum     = 32'sd76800;
	localparam logic signed [31:0] HumBias     = 32'sd2097152;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [11:0] h4;
		logic [11:0] h5;
		logic [7:0]  h6;
	} hsc_coeffs_t;

	typedef struct packed {
		logic [14:0] temp;
		logic [16:0] hum;
		logic        post;
		logic        zero;
	} hsc_side_t;

	typedef struct packed {
		logic [31:0] num;
		logic [31:0] div;
		logic [32:0] rem;
		logic [31:0] quo;
		hsc_side_t   side;
	} hsc_div_t;

	// Signed division by 2^k that truncates toward zero.
	function automatic logic signed [31:0] sdiv2(input logic signed [31:0] x,
		input logic [4:0] k);
		logic [31:0] bias;
		bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
		return signed'(x + bias) >>> k;
	endfunction

	function automatic logic signed [31:0] sx16(input logic [15:0] v);
		return signed'({{16{v[15]}}, v});
	endfunction

	function automatic logic signed [31:0] sx12(input logic [11:0] v);
		return signed'({{20{v[11]}}, v});
	endfunction

	function automatic logic signed [31:0] sx8(input logic [7:0] v);
		return signed'({{24{v[7]}}, v});
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/humidity_sensor_compensation.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  raw_pressure, raw_temperature, raw_humidity
// output    out        out_valid/out_stall  temperature_out, pressure_out, humidity_out
// config    in         APB psel/penable     paddr, pwdata, prdata (64-bit registers)
//
// One transaction is accepted per cycle while in_stall is low; a result passes
// through 12 arithmetic stages, 32 divider stages (one quotient bit each) and
// 3 closing stages. Reset clears the valid bits and the coefficients.
// A stalled output holds its result while empty stages upstream keep filling.
module humidity_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [19:0] raw_pressure,
	input  logic [19:0] raw_temperature,
	input  logic [15:0] raw_humidity,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [14:0] temperature_out,
	output logic [16:0] pressure_out,
	output logic [16:0] humidity_out
);
	logic [47:0] temp_coeffs_q;
	logic [63:0] press_a_q, press_b_q, hum_q;
	logic [15:0] press_nine_q;
	logic [2:0]  reg_idx;

	assign reg_idx = paddr[5:3];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_a_q     <= '0;
			press_b_q     <= '0;
			press_nine_q  <= '0;
			hum_q         <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				hsc_pkg::RegTempCoeffs:  temp_coeffs_q <= pwdata[47:0];
				hsc_pkg::RegPressCoeffA: press_a_q     <= pwdata;
				hsc_pkg::RegPressCoeffB: press_b_q     <= pwdata;
				hsc_pkg::RegPressCoeff9: press_nine_q  <= pwdata[15:0];
				hsc_pkg::RegHumCoeffs:   hum_q         <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			hsc_pkg::RegTempCoeffs:  prdata = {16'd0, temp_coeffs_q};
			hsc_pkg::RegPressCoeffA: prdata = press_a_q;
			hsc_pkg::RegPressCoeffB: prdata = press_b_q;
			hsc_pkg::RegPressCoeff9: prdata = {48'd0, press_nine_q};
			hsc_pkg::RegHumCoeffs:   prdata = hum_q;
			default:                 prdata = '0;
		endcase
	end

	hsc_pkg::hsc_coeffs_t coeffs;
	always_comb begin
		coeffs.t1 = temp_coeffs_q[15:0];
		coeffs.t2 = temp_coeffs_q[31:16];
		coeffs.t3 = temp_coeffs_q[47:32];
		coeffs.p1 = press_a_q[15:0];
		coeffs.p2 = press_a_q[31:16];
		coeffs.p3 = press_a_q[47:32];
		coeffs.p4 = press_a_q[63:48];
		coeffs.p5 = press_b_q[15:0];
		coeffs.p6 = press_b_q[31:16];
		coeffs.p7 = press_b_q[47:32];
		coeffs.p8 = press_b_q[63:48];
		coeffs.p9 = press_nine_q;
		coeffs.h1 = hum_q[7:0];
		coeffs.h2 = hum_q[23:8];
		coeffs.h3 = hum_q[31:24];
		coeffs.h4 = hum_q[43:32];
		coeffs.h5 = hum_q[55:44];
		coeffs.h6 = hum_q[63:56];
	end

	logic              fr_valid, fr_stall, dv_valid, dv_stall;
	hsc_pkg::hsc_div_t fr_data, dv_data;

	hsc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.coeffs          (coeffs),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.raw_humidity    (raw_humidity),
		.out_valid       (fr_valid),
		.out_stall       (fr_stall),
		.out_data        (fr_data)
	);

	hsc_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_stall  (fr_stall),
		.in_data   (fr_data),
		.out_valid (dv_valid),
		.out_stall (dv_stall),
		.out_data  (dv_data)
	);

	hsc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.coeffs          (coeffs),
		.in_valid        (dv_valid),
		.in_stall        (dv_stall),
		.in_data         (dv_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.temperature_out (temperature_out),
		.pressure_out    (pressure_out),
		.humidity_out    (humidity_out)
	);

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(temperature_out) >= -15'sd4000 &&
			$signed(temperature_out) <= 15'sd8500))
		else $error("temperature result outside its clamp range");

	a_press_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pressure_out >= 17'd30000 && pressure_out <= 17'd110000))
		else $error("pressure result outside its clamp range");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (humidity_out <= 17'd102400))
		else $error("humidity result above its clamp limit");

endmodule
`default_nettype wire

// File: rtl/core/hsc_front.sv
`default_nettype none
module hsc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hsc_pkg::hsc_coeffs_t coeffs,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [19:0]          raw_pressure,
	input  logic [19:0]          raw_temperature,
	input  logic [15:0]          raw_humidity,
	output logic                 out_valid,
	input  logic                 out_stall,
	output hsc_pkg::hsc_div_t    out_data
);
	localparam int NSt = 12;

	logic [NSt:1]   v_q;
	logic [NSt+1:1] go;

	logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;
	assign t1 = signed'({16'd0, coeffs.t1});
	assign t2 = hsc_pkg::sx16(coeffs.t2);
	assign t3 = hsc_pkg::sx16(coeffs.t3);
	assign p1 = signed'({16'd0, coeffs.p1});
	assign p2 = hsc_pkg::sx16(coeffs.p2);
	assign p3 = hsc_pkg::sx16(coeffs.p3);
	assign p4 = hsc_pkg::sx16(coeffs.p4);
	assign p5 = hsc_pkg::sx16(coeffs.p5);
	assign p6 = hsc_pkg::sx16(coeffs.p6);
	assign h1 = signed'({24'd0, coeffs.h1});
	assign h2 = hsc_pkg::sx16(coeffs.h2);
	assign h3 = signed'({24'd0, coeffs.h3});
	assign h4 = hsc_pkg::sx12(coeffs.h4);
	assign h5 = hsc_pkg::sx12(coeffs.h5);
	assign h6 = hsc_pkg::sx8(coeffs.h6);

	// A stage moves when it is empty or the stage after it moves.
	always_comb begin
		go[NSt+1] = !out_stall;
		for (int k = NSt; k >= 1; k--) begin
			go[k] = !v_q[k] || go[k+1];
		end
	end
	assign in_stall  = !go[1];
	assign out_valid = v_q[NSt];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (go[1]) v_q[1] <= in_valid;
			for (int k = 2; k <= NSt; k++) begin
				if (go[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	logic signed [31:0] ta_s1, tb_s1;
	logic [19:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7, rp_s8;
	logic [15:0] rh_s1, rh_s2, rh_s3, rh_s4, rh_s5;
	logic signed [31:0] tam_s2, tbb_s2, tam_s3, tbt_s3;
	logic signed [31:0] pa_s4, ha_s4;
	logic [14:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10,
		temp_s11, temp_s12;
	logic signed [31:0] pqq_s5, pm5_s5, pm2_s5, hd_s5, hb_s5, hc_s5;
	logic signed [31:0] pb_s6, pc_s6, pd_s6, he_s6, hb_s6, hc_s6;
	logic signed [31:0] pb_s7, pa_s7, hx_s7, he_s7;
	logic signed [31:0] pb_s8, pa_s8, hx_s8, he_s8;
	logic [31:0] num_s9, div_s9;
	logic signed [31:0] hy_s9, he_s9;
	logic [31:0] num_s10, div_s10, num_s11, div_s11, num_s12, div_s12;
	logic post_s10, zero_s10, post_s11, zero_s11, post_s12, zero_s12;
	logic signed [31:0] hcc_s10, hcc_s11, hsq_s11;
	logic [16:0] hum_s12;

	logic signed [31:0] rt32, fine, tc, pq, hrh, hq, he;
	logic [14:0] temp_c;
	logic [16:0] hum_c;

	always_comb begin
		rt32 = signed'({12'd0, raw_temperature});
		fine = tam_s3 + tbt_s3;
		tc   = hsc_pkg::sdiv2(fine * 32'sd5 + 32'sd128, 5'd8);
		if (tc < hsc_pkg::TempMin) temp_c = hsc_pkg::TempMin[14:0];
		else if (tc > hsc_pkg::TempMax) temp_c = hsc_pkg::TempMax[14:0];
		else temp_c = tc[14:0];
		pq  = hsc_pkg::sdiv2(pa_s4, 5'd2);
		hrh = signed'({2'd0, rh_s5, 14'd0});
		hq  = hsc_pkg::sdiv2(hcc_s10, 5'd15);
		he  = hcc_s11 - hsc_pkg::sdiv2(hsq_s11 * h1, 5'd4);
		if (he < 32'sd0) he = 32'sd0;
		if (he > hsc_pkg::HumLimit) he = hsc_pkg::HumLimit;
		hum_c = 17'(he >>> 12);
		if (hum_c > hsc_pkg::HumMax) hum_c = hsc_pkg::HumMax;
	end

	always_ff @(posedge clk) begin
		if (go[1]) begin
			ta_s1 <= (rt32 >>> 3) - (t1 <<< 1);
			tb_s1 <= (rt32 >>> 4) - t1;
			rp_s1 <= raw_pressure;
			rh_s1 <= raw_humidity;
		end
		if (go[2]) begin
			tam_s2 <= hsc_pkg::sdiv2(ta_s1 * t2, 5'd11);
			tbb_s2 <= hsc_pkg::sdiv2(tb_s1 * tb_s1, 5'd12);
			rp_s2  <= rp_s1;
			rh_s2  <= rh_s1;
		end
		if (go[3]) begin
			tam_s3 <= tam_s2;
			tbt_s3 <= hsc_pkg::sdiv2(tbb_s2 * t3, 5'd14);
			rp_s3  <= rp_s2;
			rh_s3  <= rh_s2;
		end
		if (go[4]) begin
			pa_s4   <= hsc_pkg::sdiv2(fine, 5'd1) - hsc_pkg::FinePress;
			ha_s4   <= fine - hsc_pkg::FineHum;
			temp_s4 <= temp_c;
			rp_s4   <= rp_s3;
			rh_s4   <= rh_s3;
		end
		if (go[5]) begin
			pqq_s5  <= pq * pq;
			pm5_s5  <= pa_s4 * p5;
			pm2_s5  <= p2 * pa_s4;
			hd_s5   <= h5 * ha_s4;
			hb_s5   <= ha_s4 * h6;
			hc_s5   <= ha_s4 * h3;
			temp_s5 <= temp_s4;
			rp_s5   <= rp_s4;
			rh_s5   <= rh_s4;
		end
		if (go[6]) begin
			pb_s6   <= hsc_pkg::sdiv2(pqq_s5, 5'd11) * p6 + (pm5_s5 <<< 1);
			pc_s6   <= hsc_pkg::sdiv2(p3 * hsc_pkg::sdiv2(pqq_s5, 5'd13), 5'd3);
			pd_s6   <= hsc_pkg::sdiv2(pm2_s5, 5'd1);
			he_s6   <= hsc_pkg::sdiv2(hrh - (h4 <<< 20) - hd_s5 + 32'sd16384, 5'd15);
			hb_s6   <= hsc_pkg::sdiv2(hb_s5, 5'd10);
			hc_s6   <= hsc_pkg::sdiv2(hc_s5, 5'd11);
			temp_s6 <= temp_s5;
			rp_s6   <= rp_s5;
		end
		if (go[7]) begin
			pb_s7   <= hsc_pkg::sdiv2(pb_s6, 5'd2) + (p4 <<< 16);
			pa_s7   <= hsc_pkg::sdiv2(pc_s6 + pd_s6, 5'd18);
			hx_s7   <= hb_s6 * (hc_s6 + 32'sd32768);
			he_s7   <= he_s6;
			temp_s7 <= temp_s6;
			rp_s7   <= rp_s6;
		end
		if (go[8]) begin
			pa_s8   <= hsc_pkg::sdiv2((32'sd32768 + pa_s7) * p1, 5'd15);
			hx_s8   <= hsc_pkg::sdiv2(hx_s7, 5'd10) + hsc_pkg::HumBias;
			pb_s8   <= pb_s7;
			he_s8   <= he_s7;
			temp_s8 <= temp_s7;
			rp_s8   <= rp_s7;
		end
		if (go[9]) begin
			div_s9  <= pa_s8;
			num_s9  <= (hsc_pkg::PressOffset - {12'd0, rp_s8}
				- unsigned'(hsc_pkg::sdiv2(pb_s8, 5'd12))) * hsc_pkg::PressScale;
			hy_s9   <= hx_s8 * h2;
			he_s9   <= he_s8;
			temp_s9 <= temp_s8;
		end
		if (go[10]) begin
			hcc_s10  <= he_s9 * hsc_pkg::sdiv2(hy_s9 + 32'sd8192, 5'd14);
			// Below 2^31 the numerator is doubled before the divide, else after.
			num_s10  <= num_s9[31] ? num_s9 : {num_s9[30:0], 1'b0};
			post_s10 <= num_s9[31];
			zero_s10 <= (div_s9 == 32'd0);
			div_s10  <= div_s9;
			temp_s10 <= temp_s9;
		end
		if (go[11]) begin
			hsq_s11  <= hsc_pkg::sdiv2(hq * hq, 5'd7);
			hcc_s11  <= hcc_s10;
			num_s11  <= num_s10;
			div_s11  <= div_s10;
			post_s11 <= post_s10;
			zero_s11 <= zero_s10;
			temp_s11 <= temp_s10;
		end
		if (go[12]) begin
			hum_s12  <= hum_c;
			num_s12  <= num_s11;
			div_s12  <= div_s11;
			post_s12 <= post_s11;
			zero_s12 <= zero_s11;
			temp_s12 <= temp_s11;
		end
	end

	always_comb begin
		out_data.num       = num_s12;
		out_data.div       = div_s12;
		out_data.rem       = '0;
		out_data.quo       = '0;
		out_data.side.temp = temp_s12;
		out_data.side.hum  = hum_s12;
		out_data.side.post = post_s12;
		out_data.side.zero = zero_s12;
	end

endmodule
`default_nettype wire

// File: rtl/core/hsc_divider.sv
`default_nettype none
module hsc_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hsc_pkg::hsc_div_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output hsc_pkg::hsc_div_t out_data
);
	localparam int NSt = hsc_pkg::DivBits;

	logic [NSt-1:0]    v_q;
	logic [NSt:0]      go;
	hsc_pkg::hsc_div_t stage_s [NSt];
	hsc_pkg::hsc_div_t nxt [NSt];

	always_comb begin
		go[NSt] = !out_stall;
		for (int k = NSt - 1; k >= 0; k--) begin
			go[k] = !v_q[k] || go[k+1];
		end
	end
	assign in_stall  = !go[0];
	assign out_valid = v_q[NSt-1];
	assign out_data  = stage_s[NSt-1];

	// One quotient bit per stage, restoring form.
	for (genvar i = 0; i < NSt; i++) begin : g_bit
		hsc_pkg::hsc_div_t src;
		logic [32:0] rsh;
		logic        fit;
		assign src = (i == 0) ? in_data : stage_s[(i == 0) ? 0 : i - 1];
		always_comb begin
			rsh = {src.rem[31:0], src.num[31]};
			fit = (rsh >= {1'b0, src.div});
			nxt[i]     = src;
			nxt[i].num = {src.num[30:0], 1'b0};
			nxt[i].rem = fit ? (rsh - {1'b0, src.div}) : rsh;
			nxt[i].quo = {src.quo[30:0], fit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (go[0]) v_q[0] <= in_valid;
			for (int k = 1; k < NSt; k++) begin
				if (go[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NSt; k++) begin
			if (go[k]) stage_s[k] <= nxt[k];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/hsc_back.sv
`default_nettype none
module hsc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hsc_pkg::hsc_coeffs_t coeffs,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  hsc_pkg::hsc_div_t    in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [14:0]          temperature_out,
	output logic [16:0]          pressure_out,
	output logic [16:0]          humidity_out
);
	logic [3:1] v_q;
	logic [4:1] go;

	logic signed [31:0] p7, p8, p9;
	assign p7 = hsc_pkg::sx16(coeffs.p7);
	assign p8 = hsc_pkg::sx16(coeffs.p8);
	assign p9 = hsc_pkg::sx16(coeffs.p9);

	always_comb begin
		go[4] = !out_stall;
		for (int k = 3; k >= 1; k--) begin
			go[k] = !v_q[k] || go[k+1];
		end
	end
	assign in_stall  = !go[1];
	assign out_valid = v_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (go[1]) v_q[1] <= in_valid;
			if (go[2]) v_q[2] <= v_q[1];
			if (go[3]) v_q[3] <= v_q[2];
		end
	end

	logic [31:0] pr, q3, qq, pr_s1, pr_s2, prf;
	logic signed [31:0] pqq_s1, pb_s1, pb_s2, pa_s2, sum;
	hsc_pkg::hsc_side_t side_s1, side_s2;
	logic [16:0] press_c;
	logic [14:0] temp_s3;
	logic [16:0] press_s3, hum_s3;

	always_comb begin
		pr  = in_data.side.post ? {in_data.quo[30:0], 1'b0} : in_data.quo;
		q3  = pr >> 3;
		qq  = q3 * q3;
		sum = hsc_pkg::sdiv2(pa_s2 + pb_s2 + p7, 5'd4);
		prf = pr_s2 + unsigned'(sum);
		if (side_s2.zero || prf < hsc_pkg::PressMin) press_c = hsc_pkg::PressMin[16:0];
		else if (prf > hsc_pkg::PressMax) press_c = hsc_pkg::PressMax[16:0];
		else press_c = prf[16:0];
	end

	always_ff @(posedge clk) begin
		if (go[1]) begin
			pr_s1   <= pr;
			pqq_s1  <= signed'(qq >> 13);
			pb_s1   <= hsc_pkg::sdiv2(signed'(pr >> 2) * p8, 5'd13);
			side_s1 <= in_data.side;
		end
		if (go[2]) begin
			pa_s2   <= hsc_pkg::sdiv2(p9 * pqq_s1, 5'd12);
			pb_s2   <= pb_s1;
			pr_s2   <= pr_s1;
			side_s2 <= side_s1;
		end
		if (go[3]) begin
			temp_s3  <= side_s2.temp;
			press_s3 <= press_c;
			hum_s3   <= side_s2.hum;
		end
	end

	assign temperature_out = temp_s3;
	assign pressure_out    = press_s3;
	assign humidity_out    = hum_s3;

endmodule
`default_nettype wire

// File: sim/humidity_sensor_compensation_checker.sv
`default_nettype none
module humidity_sensor_compensation_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [19:0] raw_pressure,
	input  wire logic [19:0] raw_temperature,
	input  wire logic [15:0] raw_humidity,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [14:0] temperature_out,
	input  wire logic [16:0] pressure_out,
	input  wire logic [16:0] humidity_out,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [14:0] temp;
		logic [16:0] press;
		logic [16:0] hum;
	} reading_t;

	logic [63:0] temp_cal, press_cal_a, press_cal_b, press_cal_9, hum_cal;
	reading_t    expected_readings[$];

	// 32-bit integer compensation; int arithmetic wraps and divides toward zero.
	function automatic reading_t compensate(input logic [19:0] rp_in,
		input logic [19:0] rt_in, input logic [15:0] rh_in);
		int unsigned rp, rt, rh, divisor, pr, q;
		int t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		int h1, h2, h3, h4, h5, h6;
		int a, b, c, d, e, fine, temp;
		reading_t r;
		rp = rp_in; rt = rt_in; rh = rh_in;
		t1 = int'(temp_cal[15:0]);
		t2 = $signed(temp_cal[31:16]);
		t3 = $signed(temp_cal[47:32]);
		p1 = int'(press_cal_a[15:0]);
		p2 = $signed(press_cal_a[31:16]);
		p3 = $signed(press_cal_a[47:32]);
		p4 = $signed(press_cal_a[63:48]);
		p5 = $signed(press_cal_b[15:0]);
		p6 = $signed(press_cal_b[31:16]);
		p7 = $signed(press_cal_b[47:32]);
		p8 = $signed(press_cal_b[63:48]);
		p9 = $signed(press_cal_9[15:0]);
		h1 = int'(hum_cal[7:0]);
		h2 = $signed(hum_cal[23:8]);
		h3 = int'(hum_cal[31:24]);
		h4 = $signed(hum_cal[43:32]);
		h5 = $signed(hum_cal[55:44]);
		h6 = $signed(hum_cal[63:56]);

		a = int'(rt / 8 - int'(t1 * 2));
		a = (a * t2) / 2048;
		b = int'(rt / 16 - int'(t1));
		b = (((b * b) / 4096) * t3) / 16384;
		fine = a + b;
		temp = (fine * 5 + 128) / 256;
		if (temp < -4000) temp = -4000;
		else if (temp > 8500) temp = 8500;

		a = fine / 2 - 64000;
		b = (((a / 4) * (a / 4)) / 2048) * p6;
		b = b + (a * p5) * 2;
		b = b / 4 + p4 * 65536;
		c = (p3 * (((a / 4) * (a / 4)) / 8192)) / 8;
		d = (p2 * a) / 2;
		a = (c + d) / 262144;
		a = ((32768 + a) * p1) / 32768;
		if (a != 0) begin
			divisor = int'(a);
			pr = (32'd1048576 - rp - int'(b / 4096)) * 32'd3125;
			if (pr < 32'h8000_0000) pr = (pr << 1) / divisor;
			else pr = (pr / divisor) * 2;
			q = pr / 8;
			a = (p9 * int'((q * q) / 8192)) / 4096;
			b = (int'(pr / 4) * p8) / 8192;
			pr = int'(int'(pr) + (a + b + p7) / 16);
			if (pr < 30000) pr = 30000;
			else if (pr > 110000) pr = 110000;
		end else begin
			pr = 30000;
		end

		a = fine - 76800;
		b = int'(rh * 16384);
		c = h4 * 1048576;
		d = h5 * a;
		e = (b - c - d + 16384) / 32768;
		b = (a * h6) / 1024;
		c = (a * h3) / 2048;
		d = (b * (c + 32768)) / 1024 + 2097152;
		b = (d * h2 + 8192) / 16384;
		c = e * b;
		d = ((c / 32768) * (c / 32768)) / 128;
		e = c - (d * h1) / 16;
		if (e < 0) e = 0;
		if (e > 419430400) e = 419430400;
		e = e / 4096;
		if (e > 102400) e = 102400;

		r.temp = temp[14:0];
		r.press = pr[16:0];
		r.hum = e[16:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			temp_cal <= '0;
			press_cal_a <= '0;
			press_cal_b <= '0;
			press_cal_9 <= '0;
			hum_cal <= '0;
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					hsc_pkg::RegTempCoeffs:  temp_cal <= {16'h0, pwdata[47:0]};
					hsc_pkg::RegPressCoeffA: press_cal_a <= pwdata;
					hsc_pkg::RegPressCoeffB: press_cal_b <= pwdata;
					hsc_pkg::RegPressCoeff9: press_cal_9 <= {48'h0, pwdata[15:0]};
					hsc_pkg::RegHumCoeffs:   hum_cal <= pwdata;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_readings.push_back(compensate(raw_pressure, raw_temperature,
					raw_humidity));
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					$error("result transaction with no sample outstanding");
					errors++;
				end else begin
					want = expected_readings.pop_front();
					if (temperature_out !== want.temp) begin
						$error("temperature_out: expected %0d, actual %0d",
							$signed(want.temp), $signed(temperature_out));
						errors++;
					end
					if (pressure_out !== want.press) begin
						$error("pressure_out: expected %0d, actual %0d",
							want.press, pressure_out);
						errors++;
					end
					if (humidity_out !== want.hum) begin
						$error("humidity_out: expected %0d, actual %0d",
							want.hum, humidity_out);
						errors++;
					end
				end
			end
			pending = expected_readings.size();
		end
	end
endmodule
`default_nettype wire

// File: sim/humidity_sensor_compensation_tb.sv
`default_nettype none
module humidity_sensor_compensation_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 5000;
	localparam int DrainCycles = 60;

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [5:0]  paddr;
	logic [63:0] pwdata, prdata;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [19:0] raw_pressure, raw_temperature;
	logic [15:0] raw_humidity;
	logic [14:0] temperature_out;
	logic [16:0] pressure_out, humidity_out;
	int          errors, pending;
	bit          steady, hold_off;
	int          quiet_cycles;

	humidity_sensor_compensation dut (.*);

	humidity_sensor_compensation_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 3'b000}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic write_all(input logic [63:0] tc, input logic [63:0] pa,
		input logic [63:0] pb, input logic [63:0] p9, input logic [63:0] hc);
		write_reg(hsc_pkg::RegTempCoeffs, tc);
		write_reg(hsc_pkg::RegPressCoeffA, pa);
		write_reg(hsc_pkg::RegPressCoeffB, pb);
		write_reg(hsc_pkg::RegPressCoeff9, p9);
		write_reg(hsc_pkg::RegHumCoeffs, hc);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic send_sample(input logic [19:0] rp, input logic [19:0] rt,
		input logic [15:0] rh);
		while (!steady && $urandom_range(0, 99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_pressure <= rp;
		raw_temperature <= rt;
		raw_humidity <= rh;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		logic [19:0] rp, rt;
		logic [15:0] rh;
		for (int i = 0; i < count; i++) begin
			// Mostly plausible readings, so the clamps do not swallow everything.
			if ($urandom_range(0, 3) != 0) begin
				rp = 20'($urandom_range(250000, 450000));
				rt = 20'($urandom_range(450000, 600000));
				rh = 16'($urandom_range(20000, 40000));
			end else begin
				rp = 20'($urandom);
				rt = 20'($urandom);
				rh = 16'($urandom);
			end
			send_sample(rp, rt, rh);
		end
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Typical factory calibration, slightly perturbed when jitter is set.
	task automatic write_typical(input bit jitter);
		logic [15:0] d;
		d = jitter ? 16'($urandom_range(0, 63)) : 16'd0;
		write_all(64'({16'(-16'sd1000), 16'd26435 + d, 16'd27504 - d}),
			{16'd2855, 16'd3024 + d, 16'(-16'sd10685), 16'd36477 + d},
			{16'(-16'sd14600), 16'd15500, 16'(-16'sd7), 16'd140 + d},
			64'({$urandom, 16'd6000 - d}),
			{8'd30, 12'd50, 12'd313 + 12'(d), 8'd0, 16'd362, 8'd75});
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		paddr = '0; pwdata = '0;
		in_valid = 1'b0;
		raw_pressure = '0; raw_temperature = '0; raw_humidity = '0;
		steady = 1'b0; hold_off = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All coefficients zero: the pressure divisor is zero.
		send_sample(20'h0, 20'h0, 16'h0);
		send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_sample(20'h5A5A5, 20'hA5A5A, 16'h5A5A);
		in_valid <= 1'b0;
		@(posedge clk);
		drain();

		write_typical(1'b0);
		send_sample(20'h0, 20'h0, 16'h0);
		send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_sample(20'hFFFFF, 20'h0, 16'hFFFF);
		send_sample(20'h0, 20'hFFFFF, 16'h0);
		send_sample(20'd415148, 20'd519888, 16'd30000);
		send_sample(20'd0, 20'd519888, 16'd0);
		send_sample(20'hFFFFF, 20'd519888, 16'hFFFF);
		send_sample(20'd300000, 20'd600000, 16'd45000);
		send_sample(20'd500000, 20'd420000, 16'd15000);
		send_random(200);
		drain();

		// Back-to-back stretch, and a long receiver hold-off to fill the pipe.
		write_typical(1'b1);
		steady = 1'b1;
		hold_off = 1'b1;
		send_random(200);
		steady = 1'b0;
		drain();

		write_all('1, '1, '1, '1, '1);
		send_random(60);
		drain();

		write_all({$urandom, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'h0001},
			{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 64'h8000,
			{8'h80, 12'h800, 12'h7FF, 8'hFF, 16'h8000, 8'h00});
		send_random(60);
		drain();

		for (int k = 0; k < 4; k++) begin
			write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom});
			send_random(60);
			drain();
		end

		write_typical(1'b1);
		send_random(200);
		drain();

		if (errors == 0) $display("humidity_sensor_compensation_tb OK");
		else $display("humidity_sensor_compensation_tb NOT OK");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= !steady && $urandom_range(0, 99) < 36;
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IdleLimit) begin
				$display("humidity_sensor_compensation_tb NOT OK");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire
